/* design/assert_macros.svh */
// Shared assertion macros for the filter block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication that is checked only outside of reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequence is checked in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/scema_pkg.sv */
package scema_pkg;

  // Fixed field widths of the request and result items.
  localparam int SampleW = 12;
  localparam int AvgW    = 16;
  localparam int AccW    = 24;
  localparam int ModeW   = 2;

  // Number of channels carried on the ports, and the first channel that
  // always uses the fixed shift.
  localparam int IoChannels = 6;
  localparam int FixedFrom  = 4;

  // Parameter defaults.
  localparam int DefChannels    = 6;
  localparam int DefSlowShift   = 8;
  localparam int DefFastShift   = 4;
  localparam int DefFixedShift  = 12;
  localparam int DefSampleBits  = 12;

  // Filter mode register codes; the remaining code behaves as frozen.
  typedef enum logic [ModeW-1:0] {
    ModeSlow   = 2'd0,
    ModeFast   = 2'd1,
    ModeFrozen = 2'd2
  } filter_mode_e;

  // One request: restart flag and six raw samples.
  typedef struct packed {
    logic               restart;
    logic [SampleW-1:0] bar_voltage_sample;
    logic [SampleW-1:0] bar_current_sample;
    logic [SampleW-1:0] out_mid_sample;
    logic [SampleW-1:0] out_rms_sample;
    logic [SampleW-1:0] temperature_sample;
    logic [SampleW-1:0] reference_sample;
  } in_item_t;

  // One result: six filtered values.
  typedef struct packed {
    logic [AvgW-1:0] bar_voltage_avg;
    logic [AvgW-1:0] bar_current_avg;
    logic [AvgW-1:0] out_mid_avg;
    logic [AvgW-1:0] out_rms_avg;
    logic [AvgW-1:0] temperature_avg;
    logic [AvgW-1:0] reference_avg;
  } out_item_t;

  // Control shared by all lanes for one accepted request.
  typedef struct packed {
    logic update;
    logic reload;
    logic fast;
  } lane_ctrl_t;

endpackage

/* design/scema_lane.sv */
`include "assert_macros.svh"

module scema_lane #(
  parameter int SLOW_SH     = scema_pkg::DefSlowShift,
  parameter int FAST_SH     = scema_pkg::DefFastShift,
  parameter int SAMPLE_BITS = scema_pkg::DefSampleBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  scema_pkg::lane_ctrl_t         ctrl_i,
  input  logic [scema_pkg::SampleW-1:0] sample_i,
  output logic [scema_pkg::AvgW-1:0]    avg_o
);

  localparam int SW  = scema_pkg::SampleW;
  localparam int AW  = scema_pkg::AvgW;
  localparam int CW  = scema_pkg::AccW;
  localparam logic [SW-1:0] SampleMask = SW'((33'd1 << SAMPLE_BITS) - 33'd1);

  logic [CW-1:0] acc_q, acc_d, acc_sum;
  logic [AW-1:0] filt_q, filt_d;
  logic [SW-1:0] sample_m;

  assign sample_m = sample_i & SampleMask;

  // Leaky integrator: add the new sample and remove the last output.
  assign acc_sum = acc_q + CW'(sample_m) - CW'(filt_q);

  // Next state: on an update, reload from the sample, or integrate and shift; else hold.
  always_comb begin
    acc_d  = acc_q;
    filt_d = filt_q;
    if (ctrl_i.update) begin
      if (ctrl_i.reload) begin
        filt_d = AW'(sample_m);
        acc_d  = ctrl_i.fast ? (CW'(sample_m) << FAST_SH) : (CW'(sample_m) << SLOW_SH);
      end else begin
        acc_d  = acc_sum;
        filt_d = ctrl_i.fast ? AW'(acc_sum >> FAST_SH) : AW'(acc_sum >> SLOW_SH);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      filt_q <= '0;
    end else begin
      acc_q  <= acc_d;
      filt_q <= filt_d;
    end
  end

  // The lane result is the filtered value after this request.
  assign avg_o = filt_d;

  `ASSERT_NEXT(a_reload_loads_sample, ctrl_i.update && ctrl_i.reload,
               filt_q == AW'($past(sample_m)), "reload did not load the sample")

endmodule

/* design/six_channel_shift_ema_filter.sv */
// Six-channel leaky-integrator filter with shift division.
//
// Input channel: in_valid_i / in_stall_o / in_data_i. A request carries six
// raw samples and a restart flag, and is accepted when valid is high and
// stall is low. One request is accepted per cycle while stall is low.
// Output channel: out_valid_o / out_stall_i / out_data_o. Each request gives
// exactly one result with the six filtered values, registered in the output
// register, or in the skid register if the output is stalled. Every lane
// does one add, one subtract and a shift per cycle. An output register plus
// a skid register decouple the two sides: a stalled result does not block
// the next request; input stalls only when the skid register is also full.
// Configuration: cfg_we_i / cfg_wdata_i write filter_mode (slow, fast,
// frozen); write it only while the block is idle.
// Reset clears all accumulators, filtered values, the pending restart,
// the mode (slow) and both output valid flags. A restart in frozen mode
// stays pending until a request arrives in slow or fast mode.
`include "assert_macros.svh"

module six_channel_shift_ema_filter #(
  parameter int CHANNELS    = scema_pkg::DefChannels,
  parameter int SLOW_SHIFT  = scema_pkg::DefSlowShift,
  parameter int FAST_SHIFT  = scema_pkg::DefFastShift,
  parameter int FIXED_SHIFT = scema_pkg::DefFixedShift,
  parameter int SAMPLE_BITS = scema_pkg::DefSampleBits
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [scema_pkg::ModeW-1:0] cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  scema_pkg::in_item_t         in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output scema_pkg::out_item_t        out_data_o
);

  localparam int NCh    = scema_pkg::IoChannels;
  localparam int Active = (CHANNELS < NCh) ? CHANNELS : NCh;

  logic [scema_pkg::ModeW-1:0]   mode_q;
  logic                          pending_q, pending_d;
  logic                          in_acc, out_take, mode_run;
  scema_pkg::lane_ctrl_t         ctrl;
  logic [scema_pkg::SampleW-1:0] lane_sample [NCh];
  logic [scema_pkg::AvgW-1:0]    lane_avg [NCh];
  scema_pkg::out_item_t          result;
  scema_pkg::out_item_t          out_q, out_d, skid_q, skid_d;
  logic                          out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;

  // Handshakes.
  assign in_stall_o = skid_valid_q;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_take   = out_valid_q && !out_stall_i;

  // Mode register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= scema_pkg::ModeSlow;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  // Restart stays pending across frozen requests.
  assign mode_run = (mode_q == scema_pkg::ModeSlow) || (mode_q == scema_pkg::ModeFast);

  always_comb begin
    pending_d = pending_q;
    if (in_acc) begin
      pending_d = mode_run ? 1'b0 : (pending_q || in_data_i.restart);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 1'b0;
    end else begin
      pending_q <= pending_d;
    end
  end

  // Lane control for this request.
  assign ctrl.update = in_acc && mode_run;
  assign ctrl.reload = pending_q || in_data_i.restart;
  assign ctrl.fast   = (mode_q == scema_pkg::ModeFast);

  assign lane_sample[0] = in_data_i.bar_voltage_sample;
  assign lane_sample[1] = in_data_i.bar_current_sample;
  assign lane_sample[2] = in_data_i.out_mid_sample;
  assign lane_sample[3] = in_data_i.out_rms_sample;
  assign lane_sample[4] = in_data_i.temperature_sample;
  assign lane_sample[5] = in_data_i.reference_sample;

  // One filter lane per active channel; the last channels use the fixed shift.
  for (genvar g = 0; g < NCh; g++) begin : g_lane
    if (g < Active) begin : g_on
      scema_lane #(
        .SLOW_SH    ((g >= scema_pkg::FixedFrom) ? FIXED_SHIFT : SLOW_SHIFT),
        .FAST_SH    ((g >= scema_pkg::FixedFrom) ? FIXED_SHIFT : FAST_SHIFT),
        .SAMPLE_BITS(SAMPLE_BITS)
      ) u_lane (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .ctrl_i  (ctrl),
        .sample_i(lane_sample[g]),
        .avg_o   (lane_avg[g])
      );
    end else begin : g_off
      assign lane_avg[g] = '0;
    end
  end

  // Merge the lane values into one result.
  assign result.bar_voltage_avg = lane_avg[0];
  assign result.bar_current_avg = lane_avg[1];
  assign result.out_mid_avg     = lane_avg[2];
  assign result.out_rms_avg     = lane_avg[3];
  assign result.temperature_avg = lane_avg[4];
  assign result.reference_avg   = lane_avg[5];

  // Output register with a skid register behind it.
  always_comb begin
    out_d        = out_q;
    skid_d       = skid_q;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (in_acc) begin
      if (!out_valid_q || out_take) begin
        out_d       = result;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = result;
        skid_valid_d = 1'b1;
      end
    end else if (out_take) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ASSERT_IMPL(a_skid_behind_out, skid_valid_q, out_valid_q,
               "skid register holds a result while the output register is empty")
  `ASSERT_NEXT(a_accept_gives_result, in_acc, out_valid_q,
               "accepted request left no result")
  `ASSERT_NEXT(a_frozen_keeps_restart, in_acc && in_data_i.restart && !mode_run,
               pending_q, "restart lost in frozen mode")

endmodule

/* bench/tb_six_channel_shift_ema_filter.sv */
module tb_six_channel_shift_ema_filter;

  // The code left over in the two-bit mode register; the block holds its state.
  localparam logic [scema_pkg::ModeW-1:0] ModeUnused = 2'd3;
  // Cycles without any handshake before the run is declared hung.
  localparam int StallLimit = 5000;
  localparam int PhaseCount = 5;
  localparam int PhaseRequests = 66;
  localparam int RestartPct = 3;
  localparam logic [scema_pkg::SampleW-1:0] SampleMax = '1;

  // Keeps its own copy of the six integrators and the expected filtered values.
  class filter_scoreboard;
    bit [scema_pkg::AccW-1:0] chan_acc [scema_pkg::IoChannels] = '{default: '0};
    bit [scema_pkg::AvgW-1:0] chan_avg [scema_pkg::IoChannels] = '{default: '0};
    bit restart_pending = 1'b0;
    logic [scema_pkg::ModeW-1:0] mode = scema_pkg::ModeSlow;
    scema_pkg::out_item_t expected_avgs [$];
    int errors = 0;
    int requests = 0;
    int results = 0;
    int restarts = 0;
    int mode_requests [4] = '{default: 0};

    function void set_mode(logic [scema_pkg::ModeW-1:0] value);
      mode = value;
    endfunction

    function int pending();
      return expected_avgs.size();
    endfunction

    // Advances the integrators by one request and queues the filtered values.
    function void note_request(scema_pkg::in_item_t req);
      bit [scema_pkg::SampleW-1:0] smp [scema_pkg::IoChannels];
      int sh;
      smp = '{req.bar_voltage_sample, req.bar_current_sample, req.out_mid_sample,
              req.out_rms_sample, req.temperature_sample, req.reference_sample};
      requests++;
      mode_requests[mode]++;
      if (req.restart) begin
        restart_pending = 1'b1;
        restarts++;
      end
      // Only slow and fast modes touch the state; a reload replaces averaging.
      if (mode == scema_pkg::ModeSlow || mode == scema_pkg::ModeFast) begin
        for (int ch = 0; ch < scema_pkg::IoChannels; ch++) begin
          if (ch >= scema_pkg::FixedFrom) sh = scema_pkg::DefFixedShift;
          else if (mode == scema_pkg::ModeSlow) sh = scema_pkg::DefSlowShift;
          else sh = scema_pkg::DefFastShift;
          if (restart_pending) begin
            chan_avg[ch] = scema_pkg::AvgW'(smp[ch]);
            chan_acc[ch] = scema_pkg::AccW'(chan_avg[ch]) << sh;
          end else begin
            chan_acc[ch] = chan_acc[ch] + scema_pkg::AccW'(smp[ch])
                           - scema_pkg::AccW'(chan_avg[ch]);
            chan_avg[ch] = scema_pkg::AvgW'(chan_acc[ch] >> sh);
          end
        end
        restart_pending = 1'b0;
      end
      expected_avgs.push_back('{chan_avg[0], chan_avg[1], chan_avg[2],
                                chan_avg[3], chan_avg[4], chan_avg[5]});
    endfunction

    function void compare_avg(string name, bit [scema_pkg::AvgW-1:0] exp,
                              logic [scema_pkg::AvgW-1:0] act);
      if (act !== exp) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp, act);
        errors++;
      end
    endfunction

    // Compares one result with the oldest expectation.
    function void check_result(scema_pkg::out_item_t res);
      scema_pkg::out_item_t exp;
      results++;
      if (expected_avgs.size() == 0) begin
        $display("%0t: result with nothing expected, expected none, got %h", $time, res);
        errors++;
        return;
      end
      exp = expected_avgs.pop_front();
      compare_avg("bar_voltage_avg", exp.bar_voltage_avg, res.bar_voltage_avg);
      compare_avg("bar_current_avg", exp.bar_current_avg, res.bar_current_avg);
      compare_avg("out_mid_avg", exp.out_mid_avg, res.out_mid_avg);
      compare_avg("out_rms_avg", exp.out_rms_avg, res.out_rms_avg);
      compare_avg("temperature_avg", exp.temperature_avg, res.temperature_avg);
      compare_avg("reference_avg", exp.reference_avg, res.reference_avg);
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [scema_pkg::ModeW-1:0] cfg_wdata_i;
  logic in_valid_i;
  logic in_stall_o;
  scema_pkg::in_item_t in_data_i;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  scema_pkg::out_item_t out_data_o;

  filter_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_cycles = 0;
  logic [scema_pkg::SampleW-1:0] level [scema_pkg::IoChannels];

  six_channel_shift_ema_filter DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #1 clk_i = ~clk_i;

  // The receiver stalls at random according to the current profile.
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // Results are checked before the request of the same edge is noted.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) sb.check_result(out_data_o);
      if (in_valid_i && !in_stall_o) sb.note_request(in_data_i);
    end
  end

  // Ends the run if no handshake happens for too long.
  initial begin
    while (stall_cycles < StallLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("%0t: no handshake for %0d cycles", $time, StallLimit);
    $display("** six_channel_shift_ema_filter: FAILED **");
    $finish;
  end

  // Offers one request after a random gap and waits until it is taken.
  task automatic send_request(scema_pkg::in_item_t req);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= req;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Stops sending and waits for every outstanding result.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Mode changes happen only with nothing in flight.
  task automatic write_filter_mode(logic [scema_pkg::ModeW-1:0] value);
    drain();
    @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_mode(value);
  endtask

  // Odd channels get one value and even channels the other.
  function automatic scema_pkg::in_item_t fill_request(bit restart,
                                                       logic [scema_pkg::SampleW-1:0] odd_val,
                                                       logic [scema_pkg::SampleW-1:0] even_val);
    return '{restart, odd_val, even_val, odd_val, even_val, odd_val, even_val};
  endfunction

  // Mixes full-range values, extremes and values close to a per-phase level.
  function automatic logic [scema_pkg::SampleW-1:0] random_sample(int ch);
    case ($urandom_range(9))
      0: return '0;
      1: return SampleMax;
      2, 3, 4: return level[ch] ^ scema_pkg::SampleW'($urandom_range(15));
      default: return scema_pkg::SampleW'($urandom_range(SampleMax));
    endcase
  endfunction

  function automatic scema_pkg::in_item_t random_request();
    scema_pkg::in_item_t req;
    req.restart = ($urandom_range(99) < RestartPct);
    req.bar_voltage_sample = random_sample(0);
    req.bar_current_sample = random_sample(1);
    req.out_mid_sample = random_sample(2);
    req.out_rms_sample = random_sample(3);
    req.temperature_sample = random_sample(4);
    req.reference_sample = random_sample(5);
    return req;
  endfunction

  // Extremes, reloads in every mode and a restart held over frozen modes.
  task automatic run_directed();
    write_filter_mode(scema_pkg::ModeSlow);
    send_request(fill_request(1'b0, '0, '0));
    send_request(fill_request(1'b0, SampleMax, SampleMax));
    send_request(fill_request(1'b0, SampleMax, SampleMax));
    send_request(fill_request(1'b1, SampleMax, SampleMax));
    send_request(fill_request(1'b1, '0, '0));
    send_request(fill_request(1'b1, 12'hAAA, 12'h555));
    send_request(fill_request(1'b0, 12'h555, 12'hAAA));
    // Going to the fast shift leaves the slow-scale accumulator behind.
    write_filter_mode(scema_pkg::ModeFast);
    send_request(fill_request(1'b0, SampleMax, SampleMax));
    send_request(fill_request(1'b0, SampleMax, '0));
    send_request(fill_request(1'b1, SampleMax, SampleMax));
    send_request(fill_request(1'b0, 12'hAAA, 12'h555));
    // A restart in frozen mode must wait for the next active request.
    write_filter_mode(scema_pkg::ModeFrozen);
    send_request(fill_request(1'b1, 12'h123, 12'hFED));
    send_request(fill_request(1'b0, SampleMax, '0));
    write_filter_mode(ModeUnused);
    send_request(fill_request(1'b0, '0, SampleMax));
    send_request(fill_request(1'b1, 12'h800, 12'h7FF));
    write_filter_mode(scema_pkg::ModeSlow);
    send_request(fill_request(1'b0, 12'h0F0, 12'hF0F));
    send_request(fill_request(1'b0, SampleMax, SampleMax));
    write_filter_mode(scema_pkg::ModeFast);
    send_request(fill_request(1'b1, '0, '0));
    send_request(fill_request(1'b0, SampleMax, SampleMax));
  endtask

  initial begin
    logic [scema_pkg::ModeW-1:0] mode_plan [PhaseCount];
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = scema_pkg::ModeSlow;
    in_valid_i = 1'b0;
    in_data_i = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 23;
    recv_idle_pct = 46;
    run_directed();

    // Three idle profiles, each walking through several mode settings.
    for (int profile = 0; profile < 3; profile++) begin
      case (profile)
        0: begin
          send_idle_pct = 23;
          recv_idle_pct = 46;
        end
        1: begin
          send_idle_pct = 46;
          recv_idle_pct = 23;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      mode_plan = '{scema_pkg::ModeSlow, scema_pkg::ModeFast, scema_pkg::ModeFrozen,
                    scema_pkg::ModeFast, scema_pkg::ModeSlow};
      if (profile == 1) mode_plan[2] = ModeUnused;
      for (int phase = 0; phase < PhaseCount; phase++) begin
        write_filter_mode(mode_plan[phase]);
        foreach (level[ch]) level[ch] = scema_pkg::SampleW'($urandom_range(SampleMax));
        for (int n = 0; n < PhaseRequests; n++) begin
          // Halfway through, hold off until the block has emptied.
          if (n == PhaseRequests / 2) drain();
          send_request(random_request());
        end
      end
    end

    drain();
    repeat (5) @(posedge clk_i);
    $display("Sent %0d requests (%0d slow, %0d fast, %0d frozen, %0d unused mode), %0d restarts.",
             sb.requests, sb.mode_requests[scema_pkg::ModeSlow],
             sb.mode_requests[scema_pkg::ModeFast],
             sb.mode_requests[scema_pkg::ModeFrozen], sb.mode_requests[ModeUnused],
             sb.restarts);
    $display("Checked %0d results under three sender and receiver idle profiles.", sb.results);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("** six_channel_shift_ema_filter: PASSED **");
    end else begin
      $display("** six_channel_shift_ema_filter: FAILED **");
    end
    $finish;
  end

endmodule
